### design/ppab_pkg.sv
package ppab_pkg;

  // Highest valid palette select
  localparam logic [2:0] KIND_MAX = 3'd4;

  // Palette ROM, indexed by {kind, colour_index}
  localparam int ROM_DEPTH = 80;
  localparam logic [15:0] COLOUR_ROM [ROM_DEPTH] = '{
    // spark
    16'hFFFF, 16'hFFE0, 16'hFE40, 16'hF800, 16'h0000, 16'h8410, 16'hAD55, 16'hD69A,
    16'hFFFF, 16'hFF60, 16'hFD20, 16'hFA00, 16'h18C3, 16'h39E7, 16'h630C, 16'h9CD3,
    // fruit
    16'h07E0, 16'h0660, 16'h05E0, 16'h04C0, 16'h2720, 16'h3FA0, 16'h57E0, 16'h6FE0,
    16'h87E0, 16'h06C0, 16'h0640, 16'h05A0, 16'h04A0, 16'h3700, 16'h47C0, 16'h0000,
    // portal
    16'h801F, 16'h981F, 16'hB05F, 16'hC87F, 16'hE0BF, 16'hF0DF, 16'hF8FF, 16'hFCFF,
    16'hD81F, 16'hE05F, 16'hE89F, 16'h0000, 16'h501F, 16'h681F, 16'h783F, 16'h0000,
    // death
    16'hF800, 16'hF810, 16'hF820, 16'hF830, 16'hF840, 16'hE840, 16'hD840, 16'hC840,
    16'hF840, 16'hF860, 16'hF880, 16'hF8A0, 16'h0000, 16'h3840, 16'h5040, 16'h7040,
    // win
    16'hFFE0, 16'hFFC0, 16'hFFA0, 16'hFF80, 16'hFF60, 16'hFF40, 16'hFF20, 16'hFF00,
    16'hFEE0, 16'hFEC0, 16'hFEA0, 16'hFE80, 16'hFE60, 16'hFE40, 16'hFE20, 16'hFE00
  };

  // Frame geometry registers
  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
  } cfg_t;

  // After lookup and widening; channel 0 red, 1 green, 2 blue
  typedef struct packed {
    logic            draw;
    logic            right;
    logic [7:0]      alpha;
    logic [9:0]      ux;
    logic [9:0]      uy;
    logic [2:0][7:0] fg;
    logic [2:0][7:0] bgm;
    logic [2:0][7:0] bgr;
  } fetch_t;

  // After the multiply-accumulate
  typedef struct packed {
    logic             draw;
    logic             right;
    logic [19:0]      row_base;
    logic [9:0]       ux;
    logic [2:0][15:0] sum_m;
    logic [2:0][15:0] sum_r;
  } mix_t;

  // c * 255 / 31 = 8c + floor(7c / 31)
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [7:0] y;
    logic [7:0] t;
    y = {c, 3'b000} - {3'b000, c};
    t = y + {5'd0, y[7:5]} + 8'd1;
    return {c, 3'b000} + {5'd0, t[7:5]};
  endfunction

  // c * 255 / 63 = 4c + floor(c / 21)
  function automatic logic [7:0] widen6(input logic [5:0] c);
    logic [1:0] q;
    if (c >= 6'd63) begin
      q = 2'd3;
    end else if (c >= 6'd42) begin
      q = 2'd2;
    end else if (c >= 6'd21) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return {c, 2'b00} + {6'd0, q};
  endfunction

  // Exact floor(n / 255) for n up to 65025
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] t;
    t = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

### design/ppab_regs.sv
module ppab_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output ppab_pkg::cfg_t     cfg
);

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic [10:0] FRAME_RESET = 11'd640;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= FRAME_RESET;
      cfg.frame_height <= FRAME_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[10:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {21'd0, cfg.frame_width};
      REG_FRAME_HEIGHT: prdata = {21'd0, cfg.frame_height};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

### design/ppab_fetch.sv
module ppab_fetch (
  input  logic                clk,
  input  logic                rst,
  input  logic                enable,
  input  logic                in_valid,
  input  ppab_pkg::cfg_t      cfg,
  input  logic                alive,
  input  logic signed [10:0]  pos_x,
  input  logic signed [10:0]  pos_y,
  input  logic [2:0]          kind,
  input  logic [3:0]          colour_index,
  input  logic [7:0]          life_alpha,
  input  logic [15:0]         background_pixel,
  input  logic [15:0]         right_background_pixel,
  output logic                valid,
  output ppab_pkg::fetch_t    stage
);

  ppab_pkg::fetch_t stage_next;
  logic             kind_ok;
  logic             in_x;
  logic             in_y;
  logic [15:0]      colour;
  logic [6:0]       rom_index;

  always_comb begin
    kind_ok   = (kind <= ppab_pkg::KIND_MAX);
    in_x      = !pos_x[10] && ({1'b0, pos_x[9:0]} < cfg.frame_width);
    in_y      = !pos_y[10] && ({1'b0, pos_y[9:0]} < cfg.frame_height);
    rom_index = {kind, colour_index};
    colour    = kind_ok ? ppab_pkg::COLOUR_ROM[rom_index] : 16'd0;

    stage_next.draw  = alive && kind_ok && in_x && in_y;
    // neighbor only when alpha is high and column+1 stays inside the row
    stage_next.right = (life_alpha > 8'd128) &&
                       (({1'b0, pos_x[9:0]} + 11'd1) < cfg.frame_width);
    stage_next.alpha = life_alpha;
    stage_next.ux    = pos_x[9:0];
    stage_next.uy    = pos_y[9:0];

    // widen RGB565 to 8 bits per channel
    stage_next.fg[0]  = ppab_pkg::widen5(colour[15:11]);
    stage_next.fg[1]  = ppab_pkg::widen6(colour[10:5]);
    stage_next.fg[2]  = ppab_pkg::widen5(colour[4:0]);
    stage_next.bgm[0] = ppab_pkg::widen5(background_pixel[15:11]);
    stage_next.bgm[1] = ppab_pkg::widen6(background_pixel[10:5]);
    stage_next.bgm[2] = ppab_pkg::widen5(background_pixel[4:0]);
    stage_next.bgr[0] = ppab_pkg::widen5(right_background_pixel[15:11]);
    stage_next.bgr[1] = ppab_pkg::widen6(right_background_pixel[10:5]);
    stage_next.bgr[2] = ppab_pkg::widen5(right_background_pixel[4:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (enable) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      stage <= stage_next;
    end
  end

endmodule

### design/ppab_mix.sv
module ppab_mix (
  input  logic              clk,
  input  logic              rst,
  input  logic              enable,
  input  logic              in_valid,
  input  ppab_pkg::fetch_t  src,
  input  ppab_pkg::cfg_t    cfg,
  output logic              valid,
  output ppab_pkg::mix_t    stage
);

  ppab_pkg::mix_t stage_next;
  logic [7:0]     a_m;
  logic [7:0]     a_r;
  logic [20:0]    row_full;

  always_comb begin
    a_m = src.alpha;
    a_r = {1'b0, src.alpha[7:1]};

    // row start address, wraps at 2^20
    row_full = {11'd0, src.uy} * {10'd0, cfg.frame_width};

    stage_next.draw     = src.draw;
    stage_next.right    = src.right;
    stage_next.row_base = row_full[19:0];
    stage_next.ux       = src.ux;

    // fg*a + bg*(255-a) per channel; the right pixel uses a/2
    for (int i = 0; i < 3; i++) begin
      stage_next.sum_m[i] = ({8'd0, src.fg[i]} * {8'd0, a_m}) +
                            ({8'd0, src.bgm[i]} * {8'd0, 8'd255 - a_m});
      stage_next.sum_r[i] = ({8'd0, src.fg[i]} * {8'd0, a_r}) +
                            ({8'd0, src.bgr[i]} * {8'd0, 8'd255 - a_r});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (enable) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      stage <= stage_next;
    end
  end

endmodule

### design/ppab_pack.sv
module ppab_pack (
  input  logic             clk,
  input  logic             rst,
  input  logic             enable,
  input  logic             in_valid,
  input  ppab_pkg::mix_t   src,
  output logic             valid,
  output logic             draw,
  output logic [19:0]      pixel_address,
  output logic [15:0]      blended_pixel,
  output logic             draw_right,
  output logic [15:0]      blended_right_pixel
);

  logic [2:0][7:0] o_m;
  logic [2:0][7:0] o_r;
  logic [15:0]     pix_m;
  logic [15:0]     pix_r;
  logic [19:0]     addr;
  logic            right_ok;

  // divide by 255, pack back to RGB565
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_m[i] = ppab_pkg::div255(src.sum_m[i]);
      o_r[i] = ppab_pkg::div255(src.sum_r[i]);
    end
    pix_m    = {o_m[0][7:3], o_m[1][7:2], o_m[2][7:3]};
    pix_r    = {o_r[0][7:3], o_r[1][7:2], o_r[2][7:3]};
    addr     = src.row_base + {10'd0, src.ux};
    right_ok = src.draw && src.right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (enable) begin
      valid <= in_valid;
    end
  end

  // no-write items come out with every field zero
  always_ff @(posedge clk) begin
    if (enable) begin
      draw                <= src.draw;
      pixel_address       <= src.draw ? addr : 20'd0;
      blended_pixel       <= src.draw ? pix_m : 16'd0;
      draw_right          <= right_ok;
      blended_right_pixel <= right_ok ? pix_r : 16'd0;
    end
  end

endmodule

### design/palette_pixel_alpha_blend.sv
// Channel   Handshake             Payload
// config    psel/penable/pready   paddr, pwdata, prdata (frame_width @0, frame_height @4)
// request   in_valid / in_stall   alive, pos_x, pos_y, kind, colour_index, life_alpha,
//                                 background_pixel, right_background_pixel
// result    out_valid / out_stall draw, pixel_address, blended_pixel, draw_right,
//                                 blended_right_pixel
//
// One item per clock unless a stalled result freezes the pipe, through three register
// stages (lookup/widen, multiply-accumulate, divide/pack), each registering it in turn.
// Synchronous reset clears the stage valid bits and sets both frame registers to 640.
// When a result is held by out_stall the whole pipeline freezes, and in_stall rises
// in the same cycle; nothing is dropped or repeated.
module palette_pixel_alpha_blend (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               alive,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic [2:0]         kind,
  input  logic [3:0]         colour_index,
  input  logic [7:0]         life_alpha,
  input  logic [15:0]        background_pixel,
  input  logic [15:0]        right_background_pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               draw,
  output logic [19:0]        pixel_address,
  output logic [15:0]        blended_pixel,
  output logic               draw_right,
  output logic [15:0]        blended_right_pixel
);

  ppab_pkg::cfg_t   cfg;
  ppab_pkg::fetch_t s1;
  ppab_pkg::mix_t   s2;
  logic             v1;
  logic             v2;
  logic             enable;

  // pipeline advances unless the output holds a result that is stalled
  assign enable   = !(out_valid && out_stall);
  assign in_stall = !enable;

  ppab_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppab_fetch u_fetch (
    .clk                    (clk),
    .rst                    (rst),
    .enable                 (enable),
    .in_valid               (in_valid),
    .cfg                    (cfg),
    .alive                  (alive),
    .pos_x                  (pos_x),
    .pos_y                  (pos_y),
    .kind                   (kind),
    .colour_index           (colour_index),
    .life_alpha             (life_alpha),
    .background_pixel       (background_pixel),
    .right_background_pixel (right_background_pixel),
    .valid                  (v1),
    .stage                  (s1)
  );

  ppab_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .enable   (enable),
    .in_valid (v1),
    .src      (s1),
    .cfg      (cfg),
    .valid    (v2),
    .stage    (s2)
  );

  ppab_pack u_pack (
    .clk                 (clk),
    .rst                 (rst),
    .enable              (enable),
    .in_valid            (v2),
    .src                 (s2),
    .valid               (out_valid),
    .draw                (draw),
    .pixel_address       (pixel_address),
    .blended_pixel       (blended_pixel),
    .draw_right          (draw_right),
    .blended_right_pixel (blended_right_pixel)
  );

endmodule

### design/ppab_checker.sv
module ppab_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               draw,
  input logic [19:0]        pixel_address,
  input logic [15:0]        blended_pixel,
  input logic               draw_right,
  input logic [15:0]        blended_right_pixel
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_address) &&
      $stable(blended_pixel) && $stable(blended_right_pixel) &&
      $stable(draw) && $stable(draw_right))
    else $error("stalled result changed");

  // a no-write result carries all-zero fields
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !draw |-> !draw_right && pixel_address == 20'd0 &&
      blended_pixel == 16'd0 && blended_right_pixel == 16'd0)
    else $error("no-write result has nonzero fields");

  // neighbor write only comes with a main write
  a_right_needs_main: assert property (@(posedge clk) disable iff (rst)
    out_valid && draw_right |-> draw)
    else $error("neighbor write without main write");

  // input back-pressure only from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

bind palette_pixel_alpha_blend ppab_checker u_ppab_checker (.*);

### tb/tb_palette_pixel_alpha_blend.sv
module tb_palette_pixel_alpha_blend;
  timeunit 1ns;
  timeprecision 1ps;

  // Palette selects
  localparam logic [2:0] KIND_SPARK  = 3'd0;
  localparam logic [2:0] KIND_FRUIT  = 3'd1;
  localparam logic [2:0] KIND_PORTAL = 3'd2;
  localparam logic [2:0] KIND_DEATH  = 3'd3;
  localparam logic [2:0] KIND_WIN    = 3'd4;

  // Register byte addresses
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd4;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int NUM_PHASES     = 9;

  // Palette contents, one row per kind
  localparam logic [15:0] PALETTE [5][16] = '{
    '{16'hFFFF, 16'hFFE0, 16'hFE40, 16'hF800, 16'h0000, 16'h8410, 16'hAD55, 16'hD69A,
      16'hFFFF, 16'hFF60, 16'hFD20, 16'hFA00, 16'h18C3, 16'h39E7, 16'h630C, 16'h9CD3},
    '{16'h07E0, 16'h0660, 16'h05E0, 16'h04C0, 16'h2720, 16'h3FA0, 16'h57E0, 16'h6FE0,
      16'h87E0, 16'h06C0, 16'h0640, 16'h05A0, 16'h04A0, 16'h3700, 16'h47C0, 16'h0000},
    '{16'h801F, 16'h981F, 16'hB05F, 16'hC87F, 16'hE0BF, 16'hF0DF, 16'hF8FF, 16'hFCFF,
      16'hD81F, 16'hE05F, 16'hE89F, 16'h0000, 16'h501F, 16'h681F, 16'h783F, 16'h0000},
    '{16'hF800, 16'hF810, 16'hF820, 16'hF830, 16'hF840, 16'hE840, 16'hD840, 16'hC840,
      16'hF840, 16'hF860, 16'hF880, 16'hF8A0, 16'h0000, 16'h3840, 16'h5040, 16'h7040},
    '{16'hFFE0, 16'hFFC0, 16'hFFA0, 16'hFF80, 16'hFF60, 16'hFF40, 16'hFF20, 16'hFF00,
      16'hFEE0, 16'hFEC0, 16'hFEA0, 16'hFE80, 16'hFE60, 16'hFE40, 16'hFE20, 16'hFE00}
  };

  typedef struct packed {
    logic              alive;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [2:0]        kind;
    logic [3:0]        colour_index;
    logic [7:0]        life_alpha;
    logic [15:0]       background_pixel;
    logic [15:0]       right_background_pixel;
  } request_t;

  typedef struct packed {
    logic        draw;
    logic [19:0] pixel_address;
    logic [15:0] blended_pixel;
    logic        draw_right;
    logic [15:0] blended_right_pixel;
  } pixel_write_t;

  // known: the write is typed in, else it comes from the predictor
  typedef struct {
    request_t     req;
    bit           known;
    pixel_write_t res;
  } draw_row_t;

  localparam pixel_write_t NO_WRITE = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        alive = 1'b0;
  logic signed [10:0] pos_x = '0;
  logic signed [10:0] pos_y = '0;
  logic [2:0]  kind = '0;
  logic [3:0]  colour_index = '0;
  logic [7:0]  life_alpha = '0;
  logic [15:0] background_pixel = '0;
  logic [15:0] right_background_pixel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        draw;
  logic [19:0] pixel_address;
  logic [15:0] blended_pixel;
  logic        draw_right;
  logic [15:0] blended_right_pixel;

  palette_pixel_alpha_blend dut (.*);

  always #1 clk = ~clk;

  // Shadow copy of the frame geometry
  int cfg_width  = 640;
  int cfg_height = 640;

  draw_row_t    issued_requests[$];
  pixel_write_t pending_writes[$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;

  // 5/6-bit channel to 8 bits, truncating
  function automatic int expand5(input logic [4:0] c);
    return (int'(c) * 255) / 31;
  endfunction

  function automatic int expand6(input logic [5:0] c);
    return (int'(c) * 255) / 63;
  endfunction

  // Blend a widened foreground over an RGB565 background and repack
  function automatic logic [15:0] blend565(input int fr, input int fgn, input int fb,
                                           input logic [15:0] bg, input int a);
    int cr, cg, cb;
    cr = (fr  * a + expand5(bg[15:11]) * (255 - a)) / 255;
    cg = (fgn * a + expand6(bg[10:5])  * (255 - a)) / 255;
    cb = (fb  * a + expand5(bg[4:0])   * (255 - a)) / 255;
    return {5'(cr >> 3), 6'(cg >> 2), 5'(cb >> 3)};
  endfunction

  function automatic pixel_write_t predict_write(input request_t r);
    pixel_write_t o;
    int x, y, a, fr, fgn, fb;
    logic [15:0] colour;
    o = NO_WRITE;
    x = int'(r.pos_x);
    y = int'(r.pos_y);
    a = int'(r.life_alpha);
    if (!r.alive || r.kind > KIND_WIN || x < 0 || y < 0 || x >= cfg_width ||
        y >= cfg_height) begin
      return o;
    end
    colour = PALETTE[r.kind][r.colour_index];
    fr  = expand5(colour[15:11]);
    fgn = expand6(colour[10:5]);
    fb  = expand5(colour[4:0]);
    o.draw = 1'b1;
    o.pixel_address = 20'(y * cfg_width + x);
    o.blended_pixel = blend565(fr, fgn, fb, r.background_pixel, a);
    // neighbour only for mostly opaque particles inside the row
    if (a > 128 && x + 1 < cfg_width) begin
      o.draw_right = 1'b1;
      o.blended_right_pixel = blend565(fr, fgn, fb, r.right_background_pixel, a / 2);
    end
    return o;
  endfunction

  function automatic request_t request_at(input bit a, input int x, input int y,
                                          input logic [2:0] k, input int idx,
                                          input int alpha, input logic [15:0] bg,
                                          input logic [15:0] bgr);
    request_t r;
    r.alive = a;
    r.pos_x = 11'(x);
    r.pos_y = 11'(y);
    r.kind = k;
    r.colour_index = 4'(idx);
    r.life_alpha = 8'(alpha);
    r.background_pixel = bg;
    r.right_background_pixel = bgr;
    return r;
  endfunction

  // Mostly live in-frame requests, the rest raw noise
  function automatic request_t random_request();
    request_t r;
    int xlim, ylim;
    r.alive = 1'($urandom);
    r.pos_x = 11'($urandom);
    r.pos_y = 11'($urandom);
    r.kind = 3'($urandom);
    r.colour_index = 4'($urandom);
    r.life_alpha = 8'($urandom);
    r.background_pixel = 16'($urandom);
    r.right_background_pixel = 16'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      xlim = (cfg_width > 1024) ? 1024 : cfg_width;
      ylim = (cfg_height > 1024) ? 1024 : cfg_height;
      r.alive = ($urandom_range(0, 19) != 0);
      r.kind = 3'($urandom_range(0, int'(KIND_WIN)));
      if (xlim > 0) begin
        case ($urandom_range(0, 3))
          0: r.pos_x = 11'(xlim - 1);
          1: r.pos_x = '0;
          default: r.pos_x = 11'($urandom_range(0, xlim - 1));
        endcase
      end
      if (ylim > 0) begin
        case ($urandom_range(0, 3))
          0: r.pos_y = 11'(ylim - 1);
          1: r.pos_y = '0;
          default: r.pos_y = 11'($urandom_range(0, ylim - 1));
        endcase
      end
      // alpha around the neighbour threshold and at the ends
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: r.life_alpha = 8'd0;
          1: r.life_alpha = 8'd128;
          2: r.life_alpha = 8'd129;
          default: r.life_alpha = 8'd255;
        endcase
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  // Register write: setup then access, done when pready is seen high
  task automatic cfg_write(input logic [2:0] addr, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_FRAME_WIDTH) cfg_width = value & 32'h7FF;
    else cfg_height = value & 32'h7FF;
  endtask

  // Send one item; bursts of random length separated by random gaps
  task automatic issue(input draw_row_t row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    issued_requests.push_back(row);
    in_valid <= 1'b1;
    alive <= row.req.alive;
    pos_x <= row.req.pos_x;
    pos_y <= row.req.pos_y;
    kind <= row.req.kind;
    colour_index <= row.req.colour_index;
    life_alpha <= row.req.life_alpha;
    background_pixel <= row.req.background_pixel;
    right_background_pixel <= row.req.right_background_pixel;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off until every pending write has come out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_writes.size() != 0 || issued_requests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver stall pattern: modes of random length
  int          stall_mode = 0;
  int          stall_left = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= stall_tick[2];
    endcase
  end

  // Handshake monitor: expectation on each accepted request, check each result
  always @(posedge clk) begin : monitor
    draw_row_t    row;
    pixel_write_t got;
    pixel_write_t want;
    bit           moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        row = issued_requests.pop_front();
        want = row.known ? row.res : predict_write(row.req);
        pending_writes.push_back(want);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got = '{draw, pixel_address, blended_pixel, draw_right, blended_right_pixel};
        if (pending_writes.size() == 0) begin
          note_mismatch($sformatf("unexpected write draw=%0b addr=%h pix=%h dr=%0b rpix=%h",
                                  got.draw, got.pixel_address, got.blended_pixel,
                                  got.draw_right, got.blended_right_pixel));
        end else begin
          want = pending_writes.pop_front();
          if (got !== want) begin
            note_mismatch($sformatf(
              "draw %0b/%0b addr %h/%h pix %h/%h dr %0b/%0b rpix %h/%h (got/exp)",
              got.draw, want.draw, got.pixel_address, want.pixel_address,
              got.blended_pixel, want.blended_pixel, got.draw_right, want.draw_right,
              got.blended_right_pixel, want.blended_right_pixel));
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog on a stuck handshake
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    draw_row_t directed[$];
    int phase_w[NUM_PHASES] = '{1024, 1, 0, 640, 2047, 1024, 37, 0, 0};
    int phase_h[NUM_PHASES] = '{1024, 1, 640, 0, 2047, 1, 500, 0, 0};
    int phase_n[NUM_PHASES] = '{200, 60, 40, 40, 150, 80, 150, 150, 130};
    int w, h;

    // Reset geometry is 640 x 640
    // dead, unknown kinds, off-frame on every side
    directed.push_back('{request_at(0, 5, 5, KIND_SPARK, 0, 255, 16'h1234, 16'h5678),
                         1'b1, NO_WRITE});
    directed.push_back('{request_at(1, 5, 5, KIND_WIN + 3'd1, 3, 255, 16'h1234, 16'h5678),
                         1'b1, NO_WRITE});
    directed.push_back('{request_at(1, 5, 5, KIND_WIN + 3'd2, 3, 200, 16'hFFFF, 16'h0000),
                         1'b1, NO_WRITE});
    directed.push_back('{request_at(1, 5, 5, KIND_WIN + 3'd3, 15, 9, 16'h0000, 16'hFFFF),
                         1'b1, NO_WRITE});
    directed.push_back('{request_at(1, -1, 5, KIND_FRUIT, 1, 255, 16'hAAAA, 16'h5555),
                         1'b1, NO_WRITE});
    directed.push_back('{request_at(1, 5, -1, KIND_FRUIT, 1, 255, 16'hAAAA, 16'h5555),
                         1'b1, NO_WRITE});
    directed.push_back('{request_at(1, -1024, -1024, KIND_DEATH, 2, 255, 16'h0F0F, 16'hF0F0),
                         1'b1, NO_WRITE});
    directed.push_back('{request_at(1, 640, 0, KIND_PORTAL, 0, 255, 16'h0001, 16'h8000),
                         1'b1, NO_WRITE});
    directed.push_back('{request_at(1, 0, 640, KIND_PORTAL, 0, 255, 16'h0001, 16'h8000),
                         1'b1, NO_WRITE});
    directed.push_back('{request_at(1, 1023, 1023, KIND_WIN, 15, 255, 16'hFFFF, 16'hFFFF),
                         1'b1, NO_WRITE});
    // opaque white on black at the origin, neighbour at half alpha
    directed.push_back('{request_at(1, 0, 0, KIND_SPARK, 0, 255, 16'h0000, 16'h0000),
                         1'b1, '{1'b1, 20'h00000, 16'hFFFF, 1'b1, 16'h7BEF}});
    // fully transparent at the last pixel keeps the background, no neighbour
    directed.push_back('{request_at(1, 639, 639, KIND_SPARK, 0, 0, 16'hFFFF, 16'hFFFF),
                         1'b1, '{1'b1, 20'h63FFF, 16'hFFFF, 1'b0, 16'h0000}});
    // right edge, alpha threshold, every palette
    directed.push_back('{request_at(1, 639, 0, KIND_WIN, 15, 255, 16'h1234, 16'h4321),
                         1'b0, NO_WRITE});
    directed.push_back('{request_at(1, 10, 5, KIND_FRUIT, 3, 128, 16'h7BEF, 16'h8410),
                         1'b0, NO_WRITE});
    directed.push_back('{request_at(1, 10, 5, KIND_FRUIT, 4, 129, 16'h7BEF, 16'h8410),
                         1'b0, NO_WRITE});
    directed.push_back('{request_at(1, 638, 100, KIND_PORTAL, 7, 200, 16'h001F, 16'hF800),
                         1'b0, NO_WRITE});
    directed.push_back('{request_at(1, 300, 200, KIND_DEATH, 12, 77, 16'h07E0, 16'h07E0),
                         1'b0, NO_WRITE});
    directed.push_back('{request_at(1, 1, 1, KIND_SPARK, 15, 254, 16'h0000, 16'hFFFF),
                         1'b0, NO_WRITE});
    directed.push_back('{request_at(1, 0, 639, KIND_WIN, 0, 1, 16'hF81F, 16'h07E0),
                         1'b0, NO_WRITE});
    directed.push_back('{request_at(1, 200, 400, KIND_PORTAL, 15, 160, 16'hAAAA, 16'h5555),
                         1'b0, NO_WRITE});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < directed.size(); i++) issue(directed[i]);
    drain();

    // Random phases, each on its own frame geometry; the last two are random sizes
    for (int p = 0; p < NUM_PHASES; p++) begin
      w = (phase_w[p] == 0 && p >= 7) ? $urandom_range(1, 1024) : phase_w[p];
      h = (phase_h[p] == 0 && p >= 7) ? $urandom_range(1, 1024) : phase_h[p];
      cfg_write(REG_FRAME_WIDTH, w);
      cfg_write(REG_FRAME_HEIGHT, h);
      repeat (phase_n[p]) issue('{random_request(), 1'b0, NO_WRITE});
      drain();
    end

    if (errors == 0 && pending_writes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
